// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the scaler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion on the block's standard clock and reset.
`define NNS_ASSERT(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- src/nns_pkg.sv -----
// ----------------------------------------------------------------------------
// nns_pkg
// Types, sizes and codes for the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nns_pkg;

  localparam int MAX_SRC_DIM = 128;
  localparam int MAX_DST_DIM = 1024;
  localparam int FRAC_BITS   = 16;

  localparam int PIX_W       = 32;
  localparam int CFG_SRC_W   = 8;
  localparam int CFG_DST_W   = 11;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 4;

  localparam int SRC_DIM_W   = $clog2(MAX_SRC_DIM + 1);
  localparam int DST_DIM_W   = $clog2(MAX_DST_DIM + 1);
  localparam int SRC_COORD_W = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1;
  localparam int COL_W       = (MAX_DST_DIM > 1) ? $clog2(MAX_DST_DIM) : 1;
  localparam int STEP_W      = SRC_DIM_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(STEP_W);
  localparam int PROD_W      = COL_W + STEP_W;
  localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FS_W        = 2 * SRC_DIM_W;

  localparam logic [CFG_SRC_W-1:0] RST_SRC_WIDTH  = CFG_SRC_W'(32);
  localparam logic [CFG_SRC_W-1:0] RST_SRC_HEIGHT = CFG_SRC_W'(32);
  localparam logic [CFG_DST_W-1:0] RST_DST_WIDTH  = CFG_DST_W'(96);
  localparam logic [CFG_DST_W-1:0] RST_DST_HEIGHT = CFG_DST_W'(96);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } nns_op_e;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } nns_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADDR,
    ST_READ,
    ST_DATA
  } nns_state_e;

  typedef struct packed {
    logic              busy;
    logic [STEP_W-1:0] step;
  } nns_div_stat_t;

endpackage

// ----- src/nns_in_if.sv -----
// ----------------------------------------------------------------------------
// nns_in_if
// Input item channel: opcode and source pixel with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nns_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [nns_pkg::PIX_W-1:0]  source_pixel;

  modport source (output valid, output opcode, output source_pixel, input ready);
  modport sink   (input valid, input opcode, input source_pixel, output ready);
endinterface

// ----- src/nns_out_if.sv -----
// ----------------------------------------------------------------------------
// nns_out_if
// Result item channel: destination pixel and frame-last mark with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nns_out_if;
  logic                       valid;
  logic                       ready;
  logic [nns_pkg::PIX_W-1:0]  dest_pixel;
  logic                       frame_last;

  modport source (output valid, output dest_pixel, output frame_last, input ready);
  modport sink   (input valid, input dest_pixel, input frame_last, output ready);
endinterface

// ----- src/nearest_neighbor_image_scaler.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbor resizer: loads source pixels into a frame store and
// emits destination pixels in raster order using 8.16 step ratios.
// ----------------------------------------------------------------------------
// Channel  | Dir | Payload                    | Accepted when
// in_i     | in  | opcode, source_pixel       | valid && ready
// out_o    | out | dest_pixel, frame_last     | valid && ready
// apb      | in  | paddr, pwdata -> prdata    | psel && penable && pwrite
//
// Load items do one frame store write each.
// Emit items pass the multiply, clamp/address, store read and output load states.
// The first emit of a frame first waits for the bit-serial step divide.
// A full output register stalls the last stage until the item is taken.
// Reset clears state, counters, steps and config registers, not the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module nearest_neighbor_image_scaler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  nns_in_if.sink                             in_i,
  nns_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nns_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [nns_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [nns_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int CW   = nns_pkg::PROD_W - nns_pkg::FRAC_BITS;
  localparam int ASUM = nns_pkg::SRC_COORD_W + nns_pkg::SRC_DIM_W;

  function automatic logic [nns_pkg::SRC_DIM_W-1:0] eff_src(
    input logic [nns_pkg::CFG_SRC_W-1:0] v
  );
    logic [nns_pkg::SRC_DIM_W-1:0] r;
    if (v == '0) begin
      r = nns_pkg::SRC_DIM_W'(1);
    end else if (int'(v) > nns_pkg::MAX_SRC_DIM) begin
      r = nns_pkg::SRC_DIM_W'(nns_pkg::MAX_SRC_DIM);
    end else begin
      r = nns_pkg::SRC_DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [nns_pkg::DST_DIM_W-1:0] eff_dst(
    input logic [nns_pkg::CFG_DST_W-1:0] v
  );
    logic [nns_pkg::DST_DIM_W-1:0] r;
    if (v == '0) begin
      r = nns_pkg::DST_DIM_W'(1);
    end else if (int'(v) > nns_pkg::MAX_DST_DIM) begin
      r = nns_pkg::DST_DIM_W'(nns_pkg::MAX_DST_DIM);
    end else begin
      r = nns_pkg::DST_DIM_W'(v);
    end
    return r;
  endfunction

  // configuration
  logic [nns_pkg::CFG_SRC_W-1:0] src_w_q, src_h_q;
  logic [nns_pkg::CFG_DST_W-1:0] dst_w_q, dst_h_q;
  nns_pkg::nns_reg_e             reg_idx;
  logic                          cfg_we;

  logic [nns_pkg::SRC_DIM_W-1:0] sw, sh;
  logic [nns_pkg::DST_DIM_W-1:0] dw, dh;
  logic [nns_pkg::FS_W-1:0]      frame_size;

  // control
  nns_pkg::nns_state_e           state_q, state_d;
  logic [nns_pkg::ADDR_W-1:0]    pos_q, pos_d, wr_addr;
  logic [nns_pkg::FS_W-1:0]      pos_inc;
  logic [nns_pkg::COL_W-1:0]     col_q, col_d, row_q, row_d;
  logic [nns_pkg::DST_DIM_W-1:0] col_inc, row_inc;
  logic                          col_wrap, row_wrap, first_px;
  logic                          out_valid_q, out_valid_d;

  logic                          in_acc, is_emit, emit_acc, ram_we, ram_re;
  logic                          div_start, out_load;

  // datapath
  logic [nns_pkg::COL_W-1:0]       idx_x_q, idx_y_q;
  logic                            last_q;
  logic [nns_pkg::PROD_W-1:0]      prod_x_q, prod_y_q;
  logic [CW-1:0]                   cx, cy;
  logic [nns_pkg::SRC_COORD_W-1:0] x_c, y_c;
  logic [ASUM-1:0]                 addr_sum;
  logic [nns_pkg::ADDR_W-1:0]      raddr_q;
  logic [nns_pkg::PIX_W-1:0]       ram_rdata;
  logic [nns_pkg::PIX_W-1:0]       out_pix_q;
  logic                            out_last_q;

  nns_pkg::nns_div_stat_t          xs, ys;

  // ---------------- configuration port ----------------
  assign reg_idx = nns_pkg::nns_reg_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      nns_pkg::REG_SRC_WIDTH:  prdata = nns_pkg::CFG_DATA_W'(src_w_q);
      nns_pkg::REG_SRC_HEIGHT: prdata = nns_pkg::CFG_DATA_W'(src_h_q);
      nns_pkg::REG_DST_WIDTH:  prdata = nns_pkg::CFG_DATA_W'(dst_w_q);
      nns_pkg::REG_DST_HEIGHT: prdata = nns_pkg::CFG_DATA_W'(dst_h_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= nns_pkg::RST_SRC_WIDTH;
      src_h_q <= nns_pkg::RST_SRC_HEIGHT;
      dst_w_q <= nns_pkg::RST_DST_WIDTH;
      dst_h_q <= nns_pkg::RST_DST_HEIGHT;
    end else if (cfg_we) begin
      unique case (reg_idx)
        nns_pkg::REG_SRC_WIDTH:  src_w_q <= pwdata[nns_pkg::CFG_SRC_W-1:0];
        nns_pkg::REG_SRC_HEIGHT: src_h_q <= pwdata[nns_pkg::CFG_SRC_W-1:0];
        nns_pkg::REG_DST_WIDTH:  dst_w_q <= pwdata[nns_pkg::CFG_DST_W-1:0];
        nns_pkg::REG_DST_HEIGHT: dst_h_q <= pwdata[nns_pkg::CFG_DST_W-1:0];
        default: ;
      endcase
    end
  end

  assign sw         = eff_src(src_w_q);
  assign sh         = eff_src(src_h_q);
  assign dw         = eff_dst(dst_w_q);
  assign dh         = eff_dst(dst_h_q);
  assign frame_size = nns_pkg::FS_W'(sw) * nns_pkg::FS_W'(sh);

  // ---------------- handshake and counters ----------------
  assign in_acc   = in_i.valid && in_i.ready;
  assign is_emit  = in_i.opcode == nns_pkg::OP_EMIT;
  assign emit_acc = in_acc && is_emit;
  assign ram_we   = in_acc && !is_emit;
  assign first_px = (col_q == '0) && (row_q == '0);

  always_comb begin
    wr_addr = (nns_pkg::FS_W'(pos_q) >= frame_size) ? '0 : pos_q;
    pos_inc = nns_pkg::FS_W'(wr_addr) + nns_pkg::FS_W'(1);
    pos_d   = pos_q;
    if (ram_we) begin
      pos_d = (pos_inc >= frame_size) ? '0 : pos_inc[nns_pkg::ADDR_W-1:0];
    end

    col_inc  = nns_pkg::DST_DIM_W'(col_q) + nns_pkg::DST_DIM_W'(1);
    row_inc  = nns_pkg::DST_DIM_W'(row_q) + nns_pkg::DST_DIM_W'(1);
    col_wrap = col_inc >= dw;
    row_wrap = row_inc >= dh;
    col_d    = col_q;
    row_d    = row_q;
    if (emit_acc) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_inc[nns_pkg::COL_W-1:0];
      end else begin
        col_d = col_inc[nns_pkg::COL_W-1:0];
      end
    end
  end

  // ---------------- state machine ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nns_pkg::ST_IDLE: begin
        if (emit_acc) begin
          state_d = first_px ? nns_pkg::ST_DIV : nns_pkg::ST_MUL;
        end
      end
      nns_pkg::ST_DIV: begin
        if (!xs.busy && !ys.busy) begin
          state_d = nns_pkg::ST_MUL;
        end
      end
      nns_pkg::ST_MUL:  state_d = nns_pkg::ST_ADDR;
      nns_pkg::ST_ADDR: state_d = nns_pkg::ST_READ;
      nns_pkg::ST_READ: state_d = nns_pkg::ST_DATA;
      nns_pkg::ST_DATA: begin
        if (out_load) begin
          state_d = nns_pkg::ST_IDLE;
        end
      end
      default: state_d = nns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = state_q == nns_pkg::ST_IDLE;
    ram_re     = state_q == nns_pkg::ST_READ;
    out_load   = (state_q == nns_pkg::ST_DATA) && (!out_valid_q || out_o.ready);
    div_start  = emit_acc && first_px;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nns_pkg::ST_IDLE;
      pos_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------- step dividers ----------------
  nns_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({sw, nns_pkg::FRAC_BITS'(0)}),
    .den_i   (dw),
    .stat_o  (xs)
  );

  nns_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({sh, nns_pkg::FRAC_BITS'(0)}),
    .den_i   (dh),
    .stat_o  (ys)
  );

  // ---------------- coordinate datapath ----------------
  always_comb begin
    cx  = prod_x_q[nns_pkg::PROD_W-1:nns_pkg::FRAC_BITS];
    cy  = prod_y_q[nns_pkg::PROD_W-1:nns_pkg::FRAC_BITS];
    x_c = (cx >= CW'(sw)) ? nns_pkg::SRC_COORD_W'(sw - nns_pkg::SRC_DIM_W'(1))
                          : nns_pkg::SRC_COORD_W'(cx);
    y_c = (cy >= CW'(sh)) ? nns_pkg::SRC_COORD_W'(sh - nns_pkg::SRC_DIM_W'(1))
                          : nns_pkg::SRC_COORD_W'(cy);
    addr_sum = ASUM'(y_c) * ASUM'(sw) + ASUM'(x_c);
  end

  always_ff @(posedge clk_i) begin
    if (emit_acc) begin
      idx_x_q <= col_q;
      idx_y_q <= row_q;
      last_q  <= col_wrap && row_wrap;
    end
    if (state_q == nns_pkg::ST_MUL) begin
      prod_x_q <= nns_pkg::PROD_W'(idx_x_q) * nns_pkg::PROD_W'(xs.step);
      prod_y_q <= nns_pkg::PROD_W'(idx_y_q) * nns_pkg::PROD_W'(ys.step);
    end
    if (state_q == nns_pkg::ST_ADDR) begin
      raddr_q <= addr_sum[nns_pkg::ADDR_W-1:0];
    end
    if (out_load) begin
      out_pix_q  <= ram_rdata;
      out_last_q <= last_q;
    end
  end

  // ---------------- frame store ----------------
  nns_ram #(
    .DEPTH (nns_pkg::STORE_DEPTH),
    .WIDTH (nns_pkg::PIX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (in_i.source_pixel),
    .re_i    (ram_re),
    .raddr_i (raddr_q),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.dest_pixel = out_pix_q;
  assign out_o.frame_last = out_last_q;

  // ---------------- assertions ----------------
  `NNS_ASSERT(a_first_divides, (emit_acc && first_px) |=> (state_q == nns_pkg::ST_DIV && xs.busy && ys.busy), "first emit of frame did not start step divide")
  `NNS_ASSERT(a_load_in_frame, ram_we |-> (nns_pkg::FS_W'(wr_addr) < frame_size), "load address outside source frame")
  `NNS_ASSERT(a_data_lands, (state_q == nns_pkg::ST_DATA && !out_valid_q) |=> (out_valid_q && state_q == nns_pkg::ST_IDLE), "result not moved to output register")

endmodule

// ----- src/nns_ram.sv -----
// ----------------------------------------------------------------------------
// nns_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nns_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/nns_div.sv -----
// ----------------------------------------------------------------------------
// nns_div
// Restoring divider for the step ratio, one quotient bit per cycle while busy.
// Holds floor(num/den)+1 as the step until the next divide completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nns_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [nns_pkg::STEP_W-1:0]        num_i,
  input  logic [nns_pkg::DST_DIM_W-1:0]     den_i,
  output nns_pkg::nns_div_stat_t            stat_o
);

  logic                              busy_q, busy_d;
  logic [nns_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [nns_pkg::STEP_W-1:0]        step_q, step_d;
  logic [nns_pkg::STEP_W-1:0]        quo_q, quo_d;
  logic [nns_pkg::DST_DIM_W-1:0]     rem_q, rem_d;
  logic [nns_pkg::DST_DIM_W-1:0]     den_q;
  logic [nns_pkg::DST_DIM_W:0]       trial;
  logic [nns_pkg::DST_DIM_W:0]       diff;
  logic                              ge;
  logic [nns_pkg::STEP_W-1:0]        quo_next;
  logic                              last_iter;

  always_comb begin
    trial     = {rem_q, quo_q[nns_pkg::STEP_W-1]};
    ge        = trial >= {1'b0, den_q};
    diff      = trial - {1'b0, den_q};
    quo_next  = {quo_q[nns_pkg::STEP_W-2:0], ge};
    last_iter = cnt_q == nns_pkg::DIV_CNT_W'(nns_pkg::STEP_W - 1);

    busy_d = busy_q;
    cnt_d  = cnt_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = quo_next;
      rem_d = ge ? diff[nns_pkg::DST_DIM_W-1:0] : trial[nns_pkg::DST_DIM_W-1:0];
      cnt_d = cnt_q + nns_pkg::DIV_CNT_W'(1);
      if (last_iter) begin
        busy_d = 1'b0;
        step_d = quo_next + nns_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.step = step_q;

endmodule
